### sv/tdpb_pkg.sv
// Shared types and constants for the tail-drop packet buffer timing unit.
`default_nettype none

package tdpb_pkg;

  // Field widths of the packet and result transactions.
  localparam int ARRIVAL_W = 32;
  localparam int PROC_W    = 16;
  localparam int TICK_W    = 34;
  localparam int CAP_W     = 11;

  // Configuration register map (word index within the APB window).
  localparam logic [0:0] REG_BUFFER_SIZE = 1'b0;

  // Reset value of the buffer capacity register.
  localparam logic [CAP_W-1:0] BUFFER_SIZE_RST = 11'd1024;

  // Finish and start times in ticks.
  typedef logic [TICK_W-1:0] tick_t;

endpackage

`default_nettype wire

### sv/tdpb_ring.sv
// Finish-time ring memory: one write port and one registered read port.
`default_nettype none

module tdpb_ring #(
  parameter int DEPTH = 1024,
  parameter int IDX_W = 10
) (
  input  wire                  clk,
  input  wire                  wr_en,
  input  wire [IDX_W-1:0]      wr_addr,
  input  tdpb_pkg::tick_t      wr_data,
  input  wire [IDX_W-1:0]      rd_addr,
  output tdpb_pkg::tick_t      rd_data
);

  tdpb_pkg::tick_t mem [DEPTH];
  tdpb_pkg::tick_t rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port: data appears the cycle after the address; a same-address write returns old data.
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

### sv/tdpb_ctrl.sv
// Sequencer: retires finished head entries, decides drop or enqueue, holds the result.
`default_nettype none

module tdpb_ctrl #(
  parameter int DEPTH = 1024,
  parameter int IDX_W = 10,
  parameter int CNT_W = 11
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire [tdpb_pkg::CAP_W-1:0]        buffer_size,
  // Packet transaction
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire [tdpb_pkg::ARRIVAL_W-1:0]    pkt_arrival,
  input  wire [tdpb_pkg::PROC_W-1:0]       pkt_ptime,
  // Result transaction
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic                             out_dropped,
  output tdpb_pkg::tick_t                  out_start,
  // Ring memory access
  output logic                             wr_en,
  output logic [IDX_W-1:0]                 wr_addr,
  output tdpb_pkg::tick_t                  wr_data,
  output logic [IDX_W-1:0]                 rd_addr,
  input  tdpb_pkg::tick_t                  rd_data
);

  localparam int CMP_W = (CNT_W > tdpb_pkg::CAP_W) ? CNT_W : tdpb_pkg::CAP_W;
  localparam logic [CMP_W-1:0] DEPTH_CMP = CMP_W'(DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(DEPTH - 1);

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_SCAN
  } state_t;

  state_t                          state_r, state_nxt;
  logic [IDX_W-1:0]                head_r, head_nxt;
  logic [IDX_W-1:0]                tail_r, tail_nxt;
  logic [CNT_W-1:0]                count_r, count_nxt;
  tdpb_pkg::tick_t                 last_r, last_nxt;
  logic [tdpb_pkg::ARRIVAL_W-1:0]  now_r, now_nxt;
  logic [tdpb_pkg::PROC_W-1:0]     ptime_r, ptime_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic                            out_drop_r, out_drop_nxt;
  tdpb_pkg::tick_t                 out_start_r, out_start_nxt;

  logic                            out_free;
  logic                            retire;
  logic                            decide;
  logic                            full;
  logic [CMP_W-1:0]                cap;
  tdpb_pkg::tick_t                 now_ext;
  tdpb_pkg::tick_t                 newest;
  tdpb_pkg::tick_t                 start;
  tdpb_pkg::tick_t                 finish;

  // Effective capacity saturates at the ring depth.
  always_comb begin
    if (CMP_W'(buffer_size) > DEPTH_CMP) begin
      cap = DEPTH_CMP;
    end else begin
      cap = CMP_W'(buffer_size);
    end
  end

  // Retire and decision terms for the packet under work.
  assign now_ext  = tdpb_pkg::TICK_W'(now_r);
  assign out_free = !out_valid_r || out_ready;
  assign retire   = (state_r == ST_SCAN) && (count_r != '0) && (rd_data <= now_ext);
  assign decide   = (state_r == ST_SCAN) && !retire && out_free;
  assign full     = CMP_W'(count_r) >= cap;
  assign newest   = (count_r != '0) ? last_r : '0;
  assign start    = (now_ext > newest) ? now_ext : newest;
  assign finish   = start + tdpb_pkg::TICK_W'(ptime_r);

  // Next-state logic.
  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    last_nxt      = last_r;
    now_nxt       = now_r;
    ptime_nxt     = ptime_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_drop_nxt  = out_drop_r;
    out_start_nxt = out_start_r;
    wr_en         = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          now_nxt   = pkt_arrival;
          ptime_nxt = pkt_ptime;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (retire) begin
          // Head entry finished by the arrival tick: pop it.
          head_nxt  = (head_r == LAST_IDX) ? '0 : head_r + 1'b1;
          count_nxt = count_r - 1'b1;
        end else if (decide) begin
          out_valid_nxt = 1'b1;
          out_drop_nxt  = full;
          if (full) begin
            out_start_nxt = '0;
          end else begin
            out_start_nxt = start;
            wr_en         = 1'b1;
            tail_nxt      = (tail_r == LAST_IDX) ? '0 : tail_r + 1'b1;
            count_nxt     = count_r + 1'b1;
            last_nxt      = finish;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
    now_r       <= now_nxt;
    ptime_r     <= ptime_nxt;
    out_drop_r  <= out_drop_nxt;
    out_start_r <= out_start_nxt;
  end

  // The memory always reads the entry that will be the head next cycle.
  assign rd_addr     = head_nxt;
  assign wr_addr     = tail_r;
  assign wr_data     = finish;
  assign in_ready    = (state_r == ST_IDLE);
  assign out_valid   = out_valid_r;
  assign out_dropped = out_drop_r;
  assign out_start   = out_start_r;

endmodule

`default_nettype wire

### sv/tail_drop_packet_buffer_timing_unit.sv
// Top level of the tail-drop packet buffer timing unit.
//
// Packets enter on the in_ stream: in_tdata carries the arrival tick and the
// processing time. For each packet one result leaves on the out_ stream:
// out_tdata carries the start tick and out_tuser flags a dropped packet.
// The buffer capacity is set through the APB port (register 0, buffer_size).
//
// A packet is accepted while the unit is idle; the unit then retires, one at
// a time, each queued finish time at the head of the ring that is due by the
// arrival tick, and then makes the drop or enqueue decision, which loads the
// output register once that register is free. No new packet is taken until
// the decision is made. Entries retire one at a time because the finish-time
// memory has a single read port.
//
// Reset empties the buffer and sets buffer_size to 1024; the memory itself is
// not cleared. While the receiver stalls, a finished result waits in the
// output register and the next packet is still taken and scanned; its
// decision waits until the output register is free.
`default_nettype none

module tail_drop_packet_buffer_timing_unit #(
  parameter int BUFFER_DEPTH = 1024
) (
  input  wire         clk,
  input  wire         rst_n,
  // Packet stream
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [47:0] in_tdata,     // [31:0] arrival tick, [47:32] service ticks
  // Result stream
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [39:0] out_tdata,    // [33:0] start tick, [39:34] zero
  output logic [0:0]  out_tuser,    // [0] dropped
  // Configuration port
  input  wire         cfg_psel,
  input  wire         cfg_penable,
  input  wire         cfg_pwrite,
  input  wire  [2:0]  cfg_paddr,
  input  wire  [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int IDX_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);

  logic [tdpb_pkg::CAP_W-1:0] buffer_size_r;
  logic                       cfg_write;
  logic                       wr_en;
  logic [IDX_W-1:0]           wr_addr;
  logic [IDX_W-1:0]           rd_addr;
  tdpb_pkg::tick_t            wr_data;
  tdpb_pkg::tick_t            rd_data;
  logic                       out_dropped;
  tdpb_pkg::tick_t            out_start;

  // Configuration register write; other word addresses are ignored.
  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr[2] == tdpb_pkg::REG_BUFFER_SIZE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buffer_size_r <= tdpb_pkg::BUFFER_SIZE_RST;
    end else if (cfg_write) begin
      buffer_size_r <= cfg_pwdata[tdpb_pkg::CAP_W-1:0];
    end
  end

  // Register readback.
  always_comb begin
    if (cfg_paddr[2] == tdpb_pkg::REG_BUFFER_SIZE) begin
      cfg_prdata = 32'(buffer_size_r);
    end else begin
      cfg_prdata = '0;
    end
  end

  tdpb_ctrl #(
    .DEPTH (BUFFER_DEPTH),
    .IDX_W (IDX_W),
    .CNT_W (CNT_W)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .buffer_size  (buffer_size_r),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .pkt_arrival  (in_tdata[31:0]),
    .pkt_ptime    (in_tdata[47:32]),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_dropped  (out_dropped),
    .out_start    (out_start),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data)
  );

  tdpb_ring #(
    .DEPTH (BUFFER_DEPTH),
    .IDX_W (IDX_W)
  ) u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Result packing.
  assign out_tdata = 40'(out_start);
  assign out_tuser = out_dropped;

endmodule

`default_nettype wire

### dv/tb_tail_drop_packet_buffer_timing_unit.sv
// Self-checking testbench for the tail-drop packet buffer timing unit.
module tb_tail_drop_packet_buffer_timing_unit;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH          = 1024;
  localparam int HEAD_W         = $clog2(DEPTH);
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_SETTLE   = 8;
  localparam int END_SETTLE     = 20;

  // Byte addresses on the APB port; word index 1 has no register behind it.
  localparam logic [2:0] ADDR_BUFFER_SIZE = {tdpb_pkg::REG_BUFFER_SIZE, 2'b00};
  localparam logic [2:0] ADDR_UNMAPPED    = 3'd4;

  // Flow-control pacing applied to the two streams.
  typedef enum int {PACE_FREE, PACE_SENDER_IDLE, PACE_RECEIVER_STALL, PACE_BOTH} pace_t;

  typedef struct packed {
    logic [tdpb_pkg::PROC_W-1:0]    ptime;
    logic [tdpb_pkg::ARRIVAL_W-1:0] arrival;
  } packet_t;

  typedef struct packed {
    logic            dropped;
    tdpb_pkg::tick_t start;
  } verdict_t;

  logic        clk;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata    = '0;   // [31:0] arrival tick, [47:32] service ticks
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [39:0] out_tdata;          // [33:0] start tick, [39:34] zero
  logic [0:0]  out_tuser;          // [0] dropped
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [2:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  tail_drop_packet_buffer_timing_unit #(.BUFFER_DEPTH(DEPTH)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // Scheduler model state: a ring of queued finish times.
  tdpb_pkg::tick_t             finish_times [DEPTH];
  logic [HEAD_W-1:0]           ring_head     = '0;
  logic [tdpb_pkg::CAP_W-1:0]  occupancy     = '0;
  tdpb_pkg::tick_t             newest_finish = '0;
  logic [tdpb_pkg::CAP_W-1:0]  capacity_reg  = tdpb_pkg::BUFFER_SIZE_RST;

  packet_t  packet_backlog[$];
  verdict_t predicted_verdicts[$];

  int          send_idle_pct = 0;
  int          stall_pct     = 0;
  int          errors        = 0;
  int          n_packets     = 0;
  int          n_drops       = 0;
  int          n_wide        = 0;
  int          n_settings    = 0;
  int          idle_cycles   = 0;
  logic [31:0] arrival_cursor = '0;

  // Retire finished packets, then either drop the new one or queue it.
  function automatic verdict_t schedule_packet(packet_t p);
    tdpb_pkg::tick_t   now;
    tdpb_pkg::tick_t   start;
    int unsigned       cap_eff;
    logic [HEAD_W-1:0] tail;
    verdict_t          v;
    now = tdpb_pkg::tick_t'(p.arrival);
    while (occupancy != 0 && finish_times[ring_head] <= now) begin
      ring_head = ring_head + 1'b1;
      occupancy = occupancy - 1'b1;
    end
    cap_eff = (capacity_reg > DEPTH) ? DEPTH : capacity_reg;
    if (occupancy >= cap_eff) begin
      v.dropped = 1'b1;
      v.start   = '0;
    end else begin
      start = (occupancy != 0 && newest_finish > now) ? newest_finish : now;
      newest_finish = start + tdpb_pkg::tick_t'(p.ptime);
      tail = ring_head + occupancy[HEAD_W-1:0];
      finish_times[tail] = newest_finish;
      occupancy = occupancy + 1'b1;
      v.dropped = 1'b0;
      v.start   = start;
    end
    return v;
  endfunction

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Packet driver: presents backlog entries, with random idle cycles.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predicted_verdicts.insert(predicted_verdicts.size(),
                                  schedule_packet(packet_t'(in_tdata)));
      end
      if (!in_tvalid || in_tready) begin
        if (packet_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata  <= packet_backlog[0];
          packet_backlog.delete(0);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares each transaction with the oldest prediction.
  always @(posedge clk) begin
    verdict_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (predicted_verdicts.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, actual dropped=%0b start=%0h",
                   $time, out_tuser[0], out_tdata[tdpb_pkg::TICK_W-1:0]);
        end else begin
          want = predicted_verdicts[0];
          predicted_verdicts.delete(0);
          n_packets++;
          if (want.dropped) n_drops++;
          if (want.start[tdpb_pkg::TICK_W-1:tdpb_pkg::ARRIVAL_W] != '0) n_wide++;
          if (out_tuser[0] !== want.dropped ||
              out_tdata[tdpb_pkg::TICK_W-1:0] !== want.start) begin
            errors++;
            $display("%0t: mismatch, expected drop=%0b start=%0h, actual drop=%0b start=%0h",
                     $time, want.dropped, want.start, out_tuser[0],
                     out_tdata[tdpb_pkg::TICK_W-1:0]);
          end
        end
      end
      out_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Watchdog on cycles in which no transaction of any kind moves.
  always @(posedge clk) begin
    if (!rst_n || cfg_psel || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles = 0;
    else
      idle_cycles = idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("FAILURE");
      $finish;
    end
  end

  // Write a register, then read back buffer_size and compare.
  task automatic program_reg(input logic [2:0] addr, input logic [31:0] data);
    logic [31:0] got;
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (addr == ADDR_BUFFER_SIZE) begin
      capacity_reg = data[tdpb_pkg::CAP_W-1:0];
      n_settings++;
    end
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= ADDR_BUFFER_SIZE;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    got = cfg_prdata;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (got !== {{(32-tdpb_pkg::CAP_W){1'b0}}, capacity_reg}) begin
      errors++;
      $display("%0t: buffer_size readback, expected %0d, actual %0h",
               $time, capacity_reg, got);
    end
  endtask

  task automatic set_pace(input pace_t pace);
    send_idle_pct = (pace == PACE_SENDER_IDLE) ? 67 : (pace == PACE_BOTH) ? 23 : 0;
    stall_pct     = (pace == PACE_RECEIVER_STALL) ? 67 : (pace == PACE_BOTH) ? 23 : 0;
  endtask

  function automatic void queue_packet(input logic [31:0] arrival, input logic [15:0] ptime);
    packet_t p;
    p.arrival = arrival;
    p.ptime   = ptime;
    packet_backlog.insert(packet_backlog.size(), p);
  endfunction

  // Hold off until every packet is sent and every result is back.
  task automatic drain_phase();
    do @(negedge clk);
    while (packet_backlog.size() != 0 || in_tvalid || predicted_verdicts.size() != 0);
    repeat (DRAIN_SETTLE) @(posedge clk);
  endtask

  // One random phase: arrivals mostly creep forward, with jumps and steps back.
  task automatic run_random(input int unsigned cap, input int n, input int max_delta,
                            input int max_ptime, input int jump_pct, input pace_t pace);
    int          r;
    int unsigned d;
    logic [15:0] pt;
    program_reg(ADDR_BUFFER_SIZE, cap);
    set_pace(pace);
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < jump_pct) begin
        arrival_cursor = arrival_cursor + $urandom_range(0, 32'h00FF_FFFF);
      end else if (r < jump_pct + 5) begin
        d = $urandom_range(0, max_delta);
        arrival_cursor = (arrival_cursor > d) ? arrival_cursor - d : '0;
      end else begin
        arrival_cursor = arrival_cursor + $urandom_range(0, max_delta);
      end
      pt = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 16'hFFFF))
                                       : 16'($urandom_range(0, max_ptime));
      queue_packet(arrival_cursor, pt);
    end
    drain_phase();
  endtask

  // Test sequence.
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A write to the unmapped word must leave buffer_size at its reset value.
    program_reg(ADDR_UNMAPPED, 32'd1);

    // Empty buffer, zero and full process times, step back, retire on equality.
    set_pace(PACE_FREE);
    queue_packet(32'd0, 16'h0000);
    queue_packet(32'd0, 16'hFFFF);
    queue_packet(32'd5, 16'd1);
    queue_packet(32'd3, 16'd2);
    queue_packet(32'd65536, 16'd0);
    queue_packet(32'd200000, 16'd7);
    drain_phase();

    // Single-entry buffer: drops and retiring exactly at the finish tick.
    program_reg(ADDR_BUFFER_SIZE, 32'd1);
    set_pace(PACE_RECEIVER_STALL);
    queue_packet(32'd300000, 16'd100);
    queue_packet(32'd300050, 16'd5);
    queue_packet(32'd300100, 16'd5);
    queue_packet(32'd300104, 16'd0);
    queue_packet(32'd300105, 16'hFFFF);
    drain_phase();
    arrival_cursor = 32'd300105;

    run_random(0,    60,  100, 100, 5, PACE_FREE);
    run_random(1,    120, 50,  100, 5, PACE_SENDER_IDLE);
    run_random(3,    150, 30,  100, 5, PACE_RECEIVER_STALL);
    run_random(17,   120, 20,  300, 5, PACE_BOTH);
    run_random(1025, 100, 1000, 500, 5, PACE_FREE);
    run_random(1024, 60,  100, 200, 5, PACE_SENDER_IDLE);
    // Dense arrivals against long service fill the whole ring until it drops.
    run_random(2047, 1080, 2, 2000, 0, PACE_BOTH);

    // High arrival ticks last: finish times past 32 bits never retire again.
    program_reg(ADDR_BUFFER_SIZE, 32'd2);
    set_pace(PACE_SENDER_IDLE);
    queue_packet(32'h5555_5555, 16'hAAAA);
    queue_packet(32'hAAAA_AAAA, 16'h5555);
    queue_packet(32'h8000_0000, 16'h8000);
    queue_packet(32'h7FFF_FFFF, 16'h7FFF);
    queue_packet(32'hFFFF_FFFF, 16'hFFFF);
    queue_packet(32'hFFFF_FFFF, 16'hFFFF);
    queue_packet(32'hFFFF_FFFF, 16'h0000);
    queue_packet(32'h0000_0000, 16'd1);
    drain_phase();

    repeat (END_SETTLE) @(posedge clk);
    if (predicted_verdicts.size() != 0) begin
      errors++;
      $display("%0t: %0d predicted results never arrived", $time, predicted_verdicts.size());
    end
    $display("Checked %0d packet results under %0d capacity settings and four pacing modes;",
             n_packets, n_settings);
    $display("%0d were dropped and %0d started beyond a 32-bit tick.", n_drops, n_wide);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
